FILE: rtl/core/shape_fill_pixel_test_unit_macros.svh
// ----------------------------------------------------------------------------
// Shape fill pixel test: assertion macros
// Clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHAPE_FILL_PIXEL_TEST_UNIT_MACROS_SVH
`define SHAPE_FILL_PIXEL_TEST_UNIT_MACROS_SVH

// Same-cycle implication.
`define SFPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SFPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sfpt_pkg.sv
// ----------------------------------------------------------------------------
// sfpt_pkg
// Constants, register codes and pipeline word types of the shape fill test.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpt_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;

    localparam int PX_W    = 10;
    localparam int PY_W    = 9;
    localparam int COORD_W = 12;
    localparam int EXT_W   = 11;
    localparam int ADDR_W  = 19;
    localparam int COLOR_W = 32;
    localparam int DELTA_W = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ESQ_W   = 2 * EXT_W;
    localparam int DSUM_W  = SQ_W + 1;
    localparam int TERM_W  = SQ_W + ESQ_W;
    localparam int PROD_W  = 2 * ESQ_W;
    localparam int SUM_W   = TERM_W + 1;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic [1:0] SHAPE_CIRCLE  = 2'd0;
    localparam logic [1:0] SHAPE_ELLIPSE = 2'd1;
    localparam logic [1:0] SHAPE_RECT    = 2'd2;

    localparam logic [2:0] HALF_WHOLE = 3'd0;
    localparam logic [2:0] HALF_UPPER = 3'd1;
    localparam logic [2:0] HALF_LOWER = 3'd2;
    localparam logic [2:0] HALF_LEFT  = 3'd3;
    localparam logic [2:0] HALF_RIGHT = 3'd4;

    localparam logic [IDX_W-1:0] CFG_SHAPE_KIND  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HALF_SELECT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_REF_X       = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REF_Y       = 3'd3;
    localparam logic [IDX_W-1:0] CFG_EXTENT_A    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_EXTENT_B    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_FILL_COLOR  = 3'd6;

    typedef struct packed {
        logic [1:0]                shape_kind;
        logic [2:0]                half_select;
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic [EXT_W-1:0]          extent_a;
        logic [EXT_W-1:0]          extent_b;
        logic [COLOR_W-1:0]        fill_color;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [1:0]        shape_kind;
        logic [MAG_W-1:0]  adx;
        logic [MAG_W-1:0]  ady;
        logic              half_ok;
        logic              rect_in;
        logic              on_screen;
        logic [ADDR_W-1:0] addr;
    } t_s1;

    typedef struct packed {
        logic              valid;
        logic [1:0]        shape_kind;
        logic [TERM_W-1:0] t1;
        logic [TERM_W-1:0] t2;
        logic [PROD_W-1:0] ab2;
        logic              circ_in;
        logic              half_ok;
        logic              rect_in;
        logic              on_screen;
        logic [ADDR_W-1:0] addr;
    } t_s3;

endpackage

`default_nettype wire

FILE: rtl/core/sfpt_cfg.sv
// ----------------------------------------------------------------------------
// sfpt_cfg
// Configuration register file with a valid/ready write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpt_cfg (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [sfpt_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire [sfpt_pkg::DATA_W-1:0]  i_cfg_data,
    output sfpt_pkg::t_cfg              o_cfg
);

    sfpt_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfpt_pkg::CFG_SHAPE_KIND: begin
                    r_cfg.shape_kind <= i_cfg_data[1:0];
                end
                sfpt_pkg::CFG_HALF_SELECT: begin
                    r_cfg.half_select <= i_cfg_data[2:0];
                end
                sfpt_pkg::CFG_REF_X: begin
                    r_cfg.ref_x <= i_cfg_data[sfpt_pkg::COORD_W-1:0];
                end
                sfpt_pkg::CFG_REF_Y: begin
                    r_cfg.ref_y <= i_cfg_data[sfpt_pkg::COORD_W-1:0];
                end
                sfpt_pkg::CFG_EXTENT_A: begin
                    r_cfg.extent_a <= i_cfg_data[sfpt_pkg::EXT_W-1:0];
                end
                sfpt_pkg::CFG_EXTENT_B: begin
                    r_cfg.extent_b <= i_cfg_data[sfpt_pkg::EXT_W-1:0];
                end
                sfpt_pkg::CFG_FILL_COLOR: begin
                    r_cfg.fill_color <= i_cfg_data[sfpt_pkg::COLOR_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfpt_front.sv
// ----------------------------------------------------------------------------
// sfpt_front
// First stage: offsets from the reference point, their magnitudes, the
// rectangle and half tests, the screen bounds check and the word address.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpt_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  wire [sfpt_pkg::PX_W-1:0]   i_pixel_x,
    input  wire [sfpt_pkg::PY_W-1:0]   i_pixel_y,
    input  wire sfpt_pkg::t_cfg        i_cfg,
    output sfpt_pkg::t_s1              o_s1
);

    logic signed [sfpt_pkg::DELTA_W-1:0] w_x;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_y;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_cx;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_cy;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_dx;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_dy;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_ea;
    logic signed [sfpt_pkg::DELTA_W-1:0] w_eb;
    logic                                w_half_ok;
    sfpt_pkg::t_s1                       n_s1;
    sfpt_pkg::t_s1                       r_s1;

    assign w_x  = $signed(sfpt_pkg::DELTA_W'(i_pixel_x));
    assign w_y  = $signed(sfpt_pkg::DELTA_W'(i_pixel_y));
    assign w_cx = sfpt_pkg::DELTA_W'(i_cfg.ref_x);
    assign w_cy = sfpt_pkg::DELTA_W'(i_cfg.ref_y);
    assign w_ea = $signed(sfpt_pkg::DELTA_W'(i_cfg.extent_a));
    assign w_eb = $signed(sfpt_pkg::DELTA_W'(i_cfg.extent_b));
    assign w_dx = w_x - w_cx;
    assign w_dy = w_y - w_cy;

    // The center line belongs to every half.
    always_comb begin
        case (i_cfg.half_select)
            sfpt_pkg::HALF_UPPER: w_half_ok = (w_dy <= 0);
            sfpt_pkg::HALF_LOWER: w_half_ok = (w_dy >= 0);
            sfpt_pkg::HALF_LEFT:  w_half_ok = (w_dx <= 0);
            sfpt_pkg::HALF_RIGHT: w_half_ok = (w_dx >= 0);
            default:              w_half_ok = 1'b1;
        endcase
    end

    always_comb begin
        n_s1.valid      = i_valid;
        n_s1.shape_kind = i_cfg.shape_kind;
        n_s1.adx        = w_dx[sfpt_pkg::DELTA_W-1] ? sfpt_pkg::MAG_W'(-w_dx)
                                                    : sfpt_pkg::MAG_W'(w_dx);
        n_s1.ady        = w_dy[sfpt_pkg::DELTA_W-1] ? sfpt_pkg::MAG_W'(-w_dy)
                                                    : sfpt_pkg::MAG_W'(w_dy);
        n_s1.half_ok    = w_half_ok;
        n_s1.rect_in    = (w_dx >= 0) && (w_dx < w_ea) && (w_dy >= 0) && (w_dy < w_eb);
        n_s1.on_screen  = (int'(i_pixel_x) < sfpt_pkg::SCREEN_WIDTH)
                       && (int'(i_pixel_y) < sfpt_pkg::SCREEN_HEIGHT);
        n_s1.addr       = sfpt_pkg::ADDR_W'(sfpt_pkg::SCREEN_WIDTH)
                        * sfpt_pkg::ADDR_W'(i_pixel_y)
                        + sfpt_pkg::ADDR_W'(i_pixel_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.shape_kind <= n_s1.shape_kind;
        r_s1.adx        <= n_s1.adx;
        r_s1.ady        <= n_s1.ady;
        r_s1.half_ok    <= n_s1.half_ok;
        r_s1.rect_in    <= n_s1.rect_in;
        r_s1.on_screen  <= n_s1.on_screen;
        r_s1.addr       <= n_s1.addr;
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

FILE: rtl/core/sfpt_mult.sv
// ----------------------------------------------------------------------------
// sfpt_mult
// Second and third stages: squares of the offsets and extents, then the
// weighted ellipse terms and the circle distance compare.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpt_mult (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire sfpt_pkg::t_s1  i_s1,
    input  wire sfpt_pkg::t_cfg i_cfg,
    output sfpt_pkg::t_s3       o_s3
);

    // Second stage registers.
    logic                        r_s2_valid;
    logic [1:0]                  r_s2_shape_kind;
    logic [sfpt_pkg::SQ_W-1:0]   r_s2_dx2;
    logic [sfpt_pkg::SQ_W-1:0]   r_s2_dy2;
    logic [sfpt_pkg::ESQ_W-1:0]  r_s2_a2;
    logic [sfpt_pkg::ESQ_W-1:0]  r_s2_b2;
    logic [sfpt_pkg::ESQ_W-1:0]  r_s2_ab;
    logic                        r_s2_half_ok;
    logic                        r_s2_rect_in;
    logic                        r_s2_on_screen;
    logic [sfpt_pkg::ADDR_W-1:0] r_s2_addr;

    logic [sfpt_pkg::DSUM_W-1:0] w_d2;
    sfpt_pkg::t_s3               n_s3;
    sfpt_pkg::t_s3               r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1.valid;
        end
        r_s2_shape_kind <= i_s1.shape_kind;
        r_s2_dx2        <= sfpt_pkg::SQ_W'(i_s1.adx) * sfpt_pkg::SQ_W'(i_s1.adx);
        r_s2_dy2        <= sfpt_pkg::SQ_W'(i_s1.ady) * sfpt_pkg::SQ_W'(i_s1.ady);
        r_s2_a2         <= sfpt_pkg::ESQ_W'(i_cfg.extent_a) * sfpt_pkg::ESQ_W'(i_cfg.extent_a);
        r_s2_b2         <= sfpt_pkg::ESQ_W'(i_cfg.extent_b) * sfpt_pkg::ESQ_W'(i_cfg.extent_b);
        r_s2_ab         <= sfpt_pkg::ESQ_W'(i_cfg.extent_a) * sfpt_pkg::ESQ_W'(i_cfg.extent_b);
        r_s2_half_ok    <= i_s1.half_ok;
        r_s2_rect_in    <= i_s1.rect_in;
        r_s2_on_screen  <= i_s1.on_screen;
        r_s2_addr       <= i_s1.addr;
    end

    assign w_d2 = sfpt_pkg::DSUM_W'(r_s2_dx2) + sfpt_pkg::DSUM_W'(r_s2_dy2);

    // The ellipse inequality uses (a*b)^2 for a^2*b^2 so that each product
    // here has only one multiplier in front of the register.
    always_comb begin
        n_s3.valid      = r_s2_valid;
        n_s3.shape_kind = r_s2_shape_kind;
        n_s3.t1         = sfpt_pkg::TERM_W'(r_s2_dx2) * sfpt_pkg::TERM_W'(r_s2_b2);
        n_s3.t2         = sfpt_pkg::TERM_W'(r_s2_dy2) * sfpt_pkg::TERM_W'(r_s2_a2);
        n_s3.ab2        = sfpt_pkg::PROD_W'(r_s2_ab) * sfpt_pkg::PROD_W'(r_s2_ab);
        n_s3.circ_in    = (w_d2 <= sfpt_pkg::DSUM_W'(r_s2_a2));
        n_s3.half_ok    = r_s2_half_ok;
        n_s3.rect_in    = r_s2_rect_in;
        n_s3.on_screen  = r_s2_on_screen;
        n_s3.addr       = r_s2_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else begin
            r_s3.valid <= n_s3.valid;
        end
        r_s3.shape_kind <= n_s3.shape_kind;
        r_s3.t1         <= n_s3.t1;
        r_s3.t2         <= n_s3.t2;
        r_s3.ab2        <= n_s3.ab2;
        r_s3.circ_in    <= n_s3.circ_in;
        r_s3.half_ok    <= n_s3.half_ok;
        r_s3.rect_in    <= n_s3.rect_in;
        r_s3.on_screen  <= n_s3.on_screen;
        r_s3.addr       <= n_s3.addr;
    end

    assign o_s3 = r_s3;

endmodule

`default_nettype wire

FILE: rtl/core/sfpt_decide.sv
// ----------------------------------------------------------------------------
// sfpt_decide
// Last stage: ellipse sum compare, coverage by shape kind and the output
// register of the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpt_decide (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire sfpt_pkg::t_s3             i_s3,
    input  wire sfpt_pkg::t_cfg            i_cfg,
    output logic                           o_result_valid,
    output logic                           o_write_enable,
    output logic [sfpt_pkg::ADDR_W-1:0]    o_pixel_address,
    output logic [sfpt_pkg::COLOR_W-1:0]   o_pixel_color
);

    logic [sfpt_pkg::SUM_W-1:0]   w_lhs;
    logic                         w_ell_in;
    logic                         w_cover;
    logic                         r_valid;
    logic                         r_we;
    logic [sfpt_pkg::ADDR_W-1:0]  r_addr;
    logic [sfpt_pkg::COLOR_W-1:0] r_color;

    assign w_lhs    = sfpt_pkg::SUM_W'(i_s3.t1) + sfpt_pkg::SUM_W'(i_s3.t2);
    assign w_ell_in = (w_lhs <= sfpt_pkg::SUM_W'(i_s3.ab2));

    always_comb begin
        case (i_s3.shape_kind)
            sfpt_pkg::SHAPE_CIRCLE:  w_cover = i_s3.circ_in && i_s3.half_ok;
            sfpt_pkg::SHAPE_ELLIPSE: w_cover = w_ell_in && i_s3.half_ok;
            sfpt_pkg::SHAPE_RECT:    w_cover = i_s3.rect_in;
            default:                 w_cover = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_we    <= 1'b0;
        end else begin
            r_valid <= i_s3.valid;
            r_we    <= i_s3.valid && w_cover && i_s3.on_screen;
        end
        // A word without a write carries zero address and color.
        r_addr  <= (w_cover && i_s3.on_screen) ? i_s3.addr : '0;
        r_color <= (w_cover && i_s3.on_screen) ? i_cfg.fill_color : '0;
    end

    assign o_result_valid  = r_valid;
    assign o_write_enable  = r_we;
    assign o_pixel_address = r_we ? r_addr : '0;
    assign o_pixel_color   = r_we ? r_color : '0;

endmodule

`default_nettype wire

FILE: rtl/core/shape_fill_pixel_test_unit.sv
// A pixel accepted with start passes the geometry, squares, ellipse products
// and final compare registers; its result word is then on the ports for one
// cycle, marked by o_result_valid.
// Throughput: one pixel per cycle; the four register stages (geometry,
// squares, ellipse products, final compare) each take a new word every cycle.
// Reset (synchronous, i_rst_n low) clears valid flags and config, empties
// the pipeline; busy is high only during reset and the receiver cannot stall.
// ----------------------------------------------------------------------------
// shape_fill_pixel_test_unit
// Tests one screen pixel per cycle against a circle, ellipse or rectangle
// and gives the write enable, frame buffer word address and fill color.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shape_fill_pixel_test_unit_macros.svh"

module shape_fill_pixel_test_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire [sfpt_pkg::PX_W-1:0]       i_pixel_x,
    input  wire [sfpt_pkg::PY_W-1:0]       i_pixel_y,
    output logic                           o_result_valid,
    output logic                           o_write_enable,
    output logic [sfpt_pkg::ADDR_W-1:0]    o_pixel_address,
    output logic [sfpt_pkg::COLOR_W-1:0]   o_pixel_color,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [sfpt_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire [sfpt_pkg::DATA_W-1:0]     i_cfg_data
);

    sfpt_pkg::t_cfg w_cfg;
    sfpt_pkg::t_s1  w_s1;
    sfpt_pkg::t_s3  w_s3;
    logic           w_accept;
    logic           w_fields_zero;

    assign busy          = ~i_rst_n;
    assign w_accept      = start && !busy;
    assign w_fields_zero = (o_pixel_address == '0) && (o_pixel_color == '0);

    sfpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sfpt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (w_cfg),
        .o_s1      (w_s1)
    );

    sfpt_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .i_cfg   (w_cfg),
        .o_s3    (w_s3)
    );

    sfpt_decide u_decide (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s3            (w_s3),
        .i_cfg           (w_cfg),
        .o_result_valid  (o_result_valid),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color)
    );

    `SFPT_ASSERT_NEXT(a_accept_enters, w_accept, w_s1.valid, "accepted word did not enter")
    `SFPT_ASSERT_IMP(a_result_from_accept, o_result_valid, $past(w_accept, 4), "orphan result")
    `SFPT_ASSERT_IMP(a_we_has_strobe, o_write_enable, o_result_valid, "write without strobe")
    `SFPT_ASSERT_IMP(a_no_write_zero, !o_write_enable, w_fields_zero, "fields set without write")

endmodule

`default_nettype wire
